// ----- sv/sma_pkg.sv -----
// Shared types and constants for the small matrix arithmetic core.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

  localparam int unsigned IDX_W     = 3;   // row / column field width
  localparam int unsigned VAL_W     = 32;  // Q16.16 element width
  localparam int unsigned DIM_W     = 4;   // dimension register width
  localparam int unsigned CFG_IDX_W = 2;   // config register index width
  localparam int unsigned FIELD_W   = 2 * IDX_W + VAL_W;
  localparam int unsigned TDATA_W   = ((FIELD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W     = TDATA_W - FIELD_W;

  typedef enum logic [2:0] {
    FN_LOAD_A = 3'd0,
    FN_LOAD_B = 3'd1,
    FN_MUL    = 3'd2,
    FN_ADD    = 3'd3,
    FN_SUB    = 3'd4,
    FN_TRANS  = 3'd5
  } sma_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } sma_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } sma_state_e;

  // controller -> datapath
  typedef struct packed {
    logic             wr_a;      // load element into A
    logic             wr_b;      // load element into B
    logic             rd_en;     // issue one operand read / MAC term
    sma_func_e        op;
    logic [IDX_W-1:0] i;         // result row
    logic [IDX_W-1:0] j;         // result column
    logic [IDX_W-1:0] k;         // inner index of the dot product
    logic             first;     // first term of an element
    logic             last;      // final term of an element
    logic             load_out;  // move result into the output register
    logic             out_last;
    logic             out_err;
  } sma_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic acc_done;  // accumulator holds a finished element
    logic out_free;  // output register can take a new item this cycle
  } sma_sts_t;

endpackage

`default_nettype wire

// ----- sv/small_matrix_arithmetic_core.sv -----
// Small matrix arithmetic core: A/B stores, A*B, A+B, A-B, transpose of A.
// A*B uses one shared MAC, one term per cycle, and four pipeline stages; A+B, A-B
// and transpose send one term per element through the same pipeline; a shape
// mismatch yields an error item.
// Reset (rst_ni, async low): dimension registers to 8, pipeline and output idle;
// element stores are not cleared and read as undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module small_matrix_arithmetic_core #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // command / element stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] row_index, [5:3] col_index, [37:6] elem_value, [39:38] zero
  input  wire [sma_pkg::TDATA_W-1:0]         s_axis_tdata,
  // [2:0] func
  input  wire [2:0]                          s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [37:6] out_value, [39:38] zero
  output logic [sma_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic                               m_axis_tlast,
  // [0] error
  output logic                               m_axis_tuser,
  // dimension register writes
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [sma_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [sma_pkg::DIM_W-1:0]           cfg_data_i
);
  import sma_pkg::*;

  sma_cmd_t                cmd;
  sma_sts_t                sts;
  logic [IDX_W-1:0]        in_row, in_col;
  logic signed [VAL_W-1:0] in_value;
  logic [IDX_W-1:0]        out_row, out_col;
  logic signed [VAL_W-1:0] out_value;

  // unpack the slave-side transfer
  assign in_row   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_axis_tdata[FIELD_W-1:2*IDX_W];

  // Controller: accepts one command per transfer in idle, decodes loads into
  // store writes, checks shapes and walks i/j/k for compute runs.
  sma_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .func_i      (sma_func_e'(s_axis_tuser)),
    .row_i       (in_row),
    .col_i       (in_col),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: element stores, operand fetch, MAC pipeline with floor
  // scaling and saturation, and the registered master-side output.
  sma_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ld_row_i    (in_row),
    .ld_col_i    (in_col),
    .ld_value_i  (in_value),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

  // pack the master-side transfer
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_value, out_col, out_row};

endmodule

`default_nettype wire

// ----- sv/sma_ctrl.sv -----
// Controller FSM: config registers, loop counters, command sequencing.
// Depends on sma_pkg; drives sma_datapath through sma_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module sma_ctrl #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_valid_i,
  output logic                           s_ready_o,
  input  sma_pkg::sma_func_e             func_i,
  input  wire [sma_pkg::IDX_W-1:0]       row_i,
  input  wire [sma_pkg::IDX_W-1:0]       col_i,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [sma_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [sma_pkg::DIM_W-1:0]       cfg_data_i,
  input  sma_pkg::sma_sts_t              sts_i,
  output sma_pkg::sma_cmd_t              cmd_o
);
  import sma_pkg::*;

  sma_state_e       state_q, state_d;
  sma_func_e        op_q, op_d;
  logic [IDX_W-1:0] nr_q, nr_d, nc_q, nc_d, nk_q, nk_d;  // extents minus one
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [IDX_W-1:0] ra, ca, rb, cb;
  logic             in_range;

  // clamp to 1..MAX_DIM, return minus one
  function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] r);
    if (r == '0) begin
      return '0;
    end else if (r > DIM_W'(MAX_DIM)) begin
      return IDX_W'(MAX_DIM - 1);
    end else begin
      return IDX_W'(r - DIM_W'(1));
    end
  endfunction

  assign ra = dim_m1(rows_a_q);
  assign ca = dim_m1(cols_a_q);
  assign rb = dim_m1(rows_b_q);
  assign cb = dim_m1(cols_b_q);

  assign in_range = ({1'b0, row_i} < (IDX_W + 1)'(MAX_DIM)) &&
                    ({1'b0, col_i} < (IDX_W + 1)'(MAX_DIM));

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(8);
      cols_a_q <= DIM_W'(8);
      rows_b_q <= DIM_W'(8);
      cols_b_q <= DIM_W'(8);
    end else if (cfg_valid_i) begin
      unique case (sma_reg_e'(cfg_index_i))
        REG_ROWS_A: rows_a_q <= cfg_data_i;
        REG_COLS_A: cols_a_q <= cfg_data_i;
        REG_ROWS_B: rows_b_q <= cfg_data_i;
        REG_COLS_B: cols_b_q <= cfg_data_i;
        default:    rows_a_q <= rows_a_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= FN_LOAD_A;
      nr_q    <= '0;
      nc_q    <= '0;
      nk_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      nr_q    <= nr_d;
      nc_q    <= nc_d;
      nk_q    <= nk_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    nr_d      = nr_q;
    nc_d      = nc_q;
    nk_d      = nk_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.op  = op_q;
    cmd_o.i   = i_q;
    cmd_o.j   = j_q;
    cmd_o.k   = k_q;

    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          op_d = func_i;
          i_d  = '0;
          j_d  = '0;
          k_d  = '0;
          unique case (func_i)
            FN_LOAD_A: cmd_o.wr_a = in_range;
            FN_LOAD_B: cmd_o.wr_b = in_range;
            FN_MUL: begin
              if (ca != rb) begin
                state_d = ST_ERR;
              end else begin
                nr_d    = ra;
                nc_d    = cb;
                nk_d    = ca;
                state_d = ST_MAC;
              end
            end
            FN_ADD, FN_SUB: begin
              if ((ra != rb) || (ca != cb)) begin
                state_d = ST_ERR;
              end else begin
                nr_d    = ra;
                nc_d    = ca;
                nk_d    = '0;
                state_d = ST_MAC;
              end
            end
            FN_TRANS: begin
              nr_d    = ca;
              nc_d    = ra;
              nk_d    = '0;
              state_d = ST_MAC;
            end
            default: state_d = ST_IDLE;  // unused codes are dropped
          endcase
        end
      end

      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.i        = '0;
          cmd_o.j        = '0;
          cmd_o.out_last = 1'b1;
          cmd_o.out_err  = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      ST_MAC: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.first = (k_q == '0);
        cmd_o.last  = (k_q == nk_q);
        if (k_q == nk_q) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end

      ST_DRAIN: begin
        if (sts_i.acc_done) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_last = (i_q == nr_q) && (j_q == nc_q);
          if ((i_q == nr_q) && (j_q == nc_q)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MAC;
            if (j_q == nc_q) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  // the MAC pipeline finishes an element only while the FSM waits for it
  ap_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.acc_done |-> (state_q == ST_DRAIN))
    else $error("accumulator finished outside DRAIN");

  // loop indices never run past the latched extents
  ap_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> ((k_q <= nk_q) && (i_q <= nr_q) && (j_q <= nc_q)))
    else $error("loop index out of range");
`endif

endmodule

`default_nettype wire

// ----- sv/sma_datapath.sv -----
// Datapath: A/B element stores, operand read, shared MAC pipeline, output register.
// Depends on sma_pkg; commanded by sma_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sma_datapath #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  sma_pkg::sma_cmd_t                 cmd_i,
  output sma_pkg::sma_sts_t                 sts_o,
  input  wire [sma_pkg::IDX_W-1:0]          ld_row_i,
  input  wire [sma_pkg::IDX_W-1:0]          ld_col_i,
  input  wire signed [sma_pkg::VAL_W-1:0]   ld_value_i,
  output logic                              m_valid_o,
  input  wire                               m_ready_i,
  output logic [sma_pkg::IDX_W-1:0]         out_row_o,
  output logic [sma_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [sma_pkg::VAL_W-1:0]  out_value_o,
  output logic                              out_last_o,
  output logic                              out_err_o
);
  import sma_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned ACC_W = VAL_W + $clog2(MAX_DIM);
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic logic [AW-1:0] addr(input logic [IDX_W-1:0] r,
                                         input logic [IDX_W-1:0] c);
    return AW'(r * MAX_DIM + c);
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[VAL_W-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[VAL_W-1:0];
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

  logic [VAL_W-1:0]        store_a_q [DEPTH];
  logic [VAL_W-1:0]        store_b_q [DEPTH];
  logic [AW-1:0]           wr_addr, rd_addr_a, rd_addr_b;

  // stage 1: operands
  logic signed [VAL_W-1:0] a_rd_q, b_rd_q;
  logic                    vld1_q, first1_q, last1_q;
  sma_func_e               op1_q;
  // stage 2: product, sum, difference or pass-through
  logic signed [63:0]      val2_q, val2_d;
  logic                    vld2_q, first2_q, last2_q, mul2_q;
  // stage 3: term, scaled and saturated for products
  logic signed [ACC_W-1:0] term_q, term_d;
  logic                    vld3_q, first3_q, last3_q;
  // stage 4: accumulator
  logic signed [ACC_W-1:0] acc_q;
  logic                    acc_done_q;

  logic                    m_valid_q;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [VAL_W-1:0] out_val_q;
  logic                    out_last_q, out_err_q;

  assign wr_addr = addr(ld_row_i, ld_col_i);

  always_comb begin
    case (cmd_i.op)
      FN_MUL: begin
        rd_addr_a = addr(cmd_i.i, cmd_i.k);
        rd_addr_b = addr(cmd_i.k, cmd_i.j);
      end
      FN_TRANS: begin
        rd_addr_a = addr(cmd_i.j, cmd_i.i);
        rd_addr_b = addr(cmd_i.j, cmd_i.i);
      end
      default: begin
        rd_addr_a = addr(cmd_i.i, cmd_i.j);
        rd_addr_b = addr(cmd_i.i, cmd_i.j);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      store_a_q[wr_addr] <= ld_value_i;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= store_a_q[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      store_b_q[wr_addr] <= ld_value_i;
    end
    if (cmd_i.rd_en) begin
      b_rd_q <= store_b_q[rd_addr_b];
    end
  end

  always_comb begin
    case (op1_q)
      FN_MUL:  val2_d = 64'(a_rd_q) * 64'(b_rd_q);
      FN_ADD:  val2_d = 64'(a_rd_q) + 64'(b_rd_q);
      FN_SUB:  val2_d = 64'(a_rd_q) - 64'(b_rd_q);
      default: val2_d = 64'(a_rd_q);
    endcase
  end

  // arithmetic shift is floor division by 2^FRAC_BITS
  always_comb begin
    if (mul2_q) begin
      term_d = ACC_W'(sat32(val2_q >>> FRAC_BITS));
    end else begin
      term_d = val2_q[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q <= cmd_i.first;
    last1_q  <= cmd_i.last;
    op1_q    <= cmd_i.op;
    val2_q   <= val2_d;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    mul2_q   <= (op1_q == FN_MUL);
    term_q   <= term_d;
    first3_q <= first2_q;
    last3_q  <= last2_q;
    if (vld3_q) begin
      acc_q <= first3_q ? term_q : acc_q + term_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q     <= 1'b0;
      vld2_q     <= 1'b0;
      vld3_q     <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      vld1_q     <= cmd_i.rd_en;
      vld2_q     <= vld1_q;
      vld3_q     <= vld2_q;
      acc_done_q <= vld3_q && last3_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q  <= cmd_i.i;
      out_col_q  <= cmd_i.j;
      out_val_q  <= cmd_i.out_err ? '0 : sat32(64'(acc_q));
      out_last_q <= cmd_i.out_last;
      out_err_q  <= cmd_i.out_err;
    end
  end

  assign sts_o.acc_done = acc_done_q;
  assign sts_o.out_free = !m_valid_q || m_ready_i;

  assign m_valid_o   = m_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_val_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

`ifndef SYNTH
  // an element completes only once its terms have left the pipeline
  ap_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done_q |-> (!vld1_q && !vld2_q && !vld3_q))
    else $error("MAC pipeline not empty at element completion");

  // an error item is a single, zero-valued, final item
  ap_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_err_q) |-> (out_last_q && (out_val_q == '0)))
    else $error("malformed error item");
`endif

endmodule

`default_nettype wire
